/* src/nccm_pkg.sv */
// ----------------------------------------------------------------------------
// nccm_pkg
// Shared sizes, register indexes and controller/datapath interface types for
// the normalized cross-correlation matcher.
// ----------------------------------------------------------------------------
package nccm_pkg;

  localparam int MAX_IMAGE_WIDTH     = 1024;
  localparam int MAX_IMAGE_HEIGHT    = 1024;
  localparam int MAX_TEMPLATE_WIDTH  = 8;
  localparam int MAX_TEMPLATE_HEIGHT = 8;

  localparam int PIX_W   = 8;
  localparam int SIZE_W  = 11;
  localparam int TSIZE_W = 4;
  localparam int THR_W   = 17;
  localparam int SCORE_W = 17;
  localparam int POS_W   = 10;
  localparam int ROW_W   = $clog2(MAX_IMAGE_HEIGHT);
  localparam int COL_W   = $clog2(MAX_IMAGE_WIDTH);
  localparam int TR_W    = $clog2(MAX_TEMPLATE_HEIGHT) > 0 ? $clog2(MAX_TEMPLATE_HEIGHT) : 1;
  localparam int TC_W    = $clog2(MAX_TEMPLATE_WIDTH) > 0 ? $clog2(MAX_TEMPLATE_WIDTH) : 1;
  localparam int TDEPTH  = MAX_TEMPLATE_WIDTH * MAX_TEMPLATE_HEIGHT;
  localparam int TADDR_W = $clog2(TDEPTH) > 0 ? $clog2(TDEPTH) : 1;
  localparam int TPOS_W  = TADDR_W + 1;
  localparam int LINE_W  = (MAX_TEMPLATE_HEIGHT - 1) * PIX_W;
  localparam int ACC_W   = 2 * PIX_W + $clog2(TDEPTH);
  localparam int HALF_W  = ACC_W / 2;
  localparam int PROD_W  = 2 * ACC_W;
  localparam int NUM_W   = ACC_W + 16;
  localparam int RREM_W  = ACC_W + 4;
  localparam int DREM_W  = ACC_W + 1;
  localparam int IT_W    = $clog2(NUM_W);
  localparam int SQRT_STEPS = PROD_W / 2;
  localparam int DIV_STEPS  = NUM_W;

  localparam logic [SCORE_W-1:0] SCORE_ONE = SCORE_W'(65536);

  localparam logic [2:0] REG_IMAGE_WIDTH     = 3'd0;
  localparam logic [2:0] REG_IMAGE_HEIGHT    = 3'd1;
  localparam logic [2:0] REG_TEMPLATE_WIDTH  = 3'd2;
  localparam logic [2:0] REG_TEMPLATE_HEIGHT = 3'd3;
  localparam logic [2:0] REG_MATCH_THRESHOLD = 3'd4;

  typedef struct packed {
    logic [SIZE_W-1:0]  image_width;
    logic [SIZE_W-1:0]  image_height;
    logic [TSIZE_W-1:0] template_width;
    logic [TSIZE_W-1:0] template_height;
    logic [THR_W-1:0]   match_threshold;
  } cfg_t;

  typedef struct packed {
    logic tpl_load;
    logic img_take;
    logic img_step;
    logic acc_start;
    logic mul0;
    logic mul1;
    logic sqrt_step;
    logic div_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic acc_done;
    logic zero;
    logic sqrt_last;
    logic div_last;
  } status_t;

endpackage

/* src/normalized_cross_correlation_match.sv */
// ----------------------------------------------------------------------------
// normalized_cross_correlation_match
// Template matcher scoring every full window of a grey image stream by
// normalized cross-correlation in unsigned Q16.
// ----------------------------------------------------------------------------
// A template pixel is stored while the matcher is idle. An image pixel that
// completes no window has the line store read, then written with the window
// shifted. For a pixel that completes a window, the window is accumulated one
// product pair per cycle; unless an energy is zero, the energy product is then
// formed in two halves, the square root is resolved bit by bit and the
// division gives one quotient bit per cycle. A finished score waits in the
// output register while the next pixels are taken.
module normalized_cross_correlation_match (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_action,
  input  logic                           in_first,
  input  logic [nccm_pkg::PIX_W-1:0]     in_pixel,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [nccm_pkg::POS_W-1:0]     out_match_row,
  output logic [nccm_pkg::POS_W-1:0]     out_match_col,
  output logic [nccm_pkg::SCORE_W-1:0]   out_score,
  output logic                           out_zero_energy,
  output logic                           out_above_threshold,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [2:0]                     cfg_index,
  input  logic [nccm_pkg::THR_W-1:0]     cfg_data
);

  nccm_pkg::cfg_t    cfg_r;
  nccm_pkg::cmd_t    cmd;
  nccm_pkg::status_t st;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.image_width     <= nccm_pkg::SIZE_W'(1024);
      cfg_r.image_height    <= nccm_pkg::SIZE_W'(1024);
      cfg_r.template_width  <= nccm_pkg::TSIZE_W'(8);
      cfg_r.template_height <= nccm_pkg::TSIZE_W'(8);
      cfg_r.match_threshold <= nccm_pkg::THR_W'(63570);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        nccm_pkg::REG_IMAGE_WIDTH:
          cfg_r.image_width <= cfg_data[nccm_pkg::SIZE_W-1:0];
        nccm_pkg::REG_IMAGE_HEIGHT:
          cfg_r.image_height <= cfg_data[nccm_pkg::SIZE_W-1:0];
        nccm_pkg::REG_TEMPLATE_WIDTH:
          cfg_r.template_width <= cfg_data[nccm_pkg::TSIZE_W-1:0];
        nccm_pkg::REG_TEMPLATE_HEIGHT:
          cfg_r.template_height <= cfg_data[nccm_pkg::TSIZE_W-1:0];
        nccm_pkg::REG_MATCH_THRESHOLD:
          cfg_r.match_threshold <= cfg_data;
        default: ;
      endcase
    end
  end

  nccm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_action (in_action),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .st        (st),
    .cmd       (cmd)
  );

  nccm_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_first  (in_first),
    .in_pixel  (in_pixel),
    .cmd       (cmd),
    .st        (st),
    .res_row   (out_match_row),
    .res_col   (out_match_col),
    .res_score (out_score),
    .res_zero  (out_zero_energy),
    .res_above (out_above_threshold)
  );

  a_score_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_score <= nccm_pkg::SCORE_ONE)
    else $error("score above one");

  a_zero_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_zero_energy |-> out_score == '0 && !out_above_threshold)
    else $error("zero energy result not cleared");

  a_above_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_above_threshold == (out_score > cfg_r.match_threshold))
    else $error("threshold flag mismatch");

endmodule

/* src/nccm_dp.sv */
// ----------------------------------------------------------------------------
// nccm_dp
// Datapath: template and line stores, window registers, correlation
// accumulation, energy product, iterative square root and division.
// ----------------------------------------------------------------------------
module nccm_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  nccm_pkg::cfg_t                cfg,
  input  logic                          in_first,
  input  logic [nccm_pkg::PIX_W-1:0]    in_pixel,
  input  nccm_pkg::cmd_t                cmd,
  output nccm_pkg::status_t             st,
  output logic [nccm_pkg::POS_W-1:0]    res_row,
  output logic [nccm_pkg::POS_W-1:0]    res_col,
  output logic [nccm_pkg::SCORE_W-1:0]  res_score,
  output logic                          res_zero,
  output logic                          res_above
);

  localparam int TH = nccm_pkg::MAX_TEMPLATE_HEIGHT;
  localparam int TW = nccm_pkg::MAX_TEMPLATE_WIDTH;
  localparam int PW = nccm_pkg::PIX_W;

  // clamped sizes
  logic [nccm_pkg::SIZE_W-1:0]  iw, ih;
  logic [nccm_pkg::TSIZE_W-1:0] tw, th;
  logic [nccm_pkg::TPOS_W-1:0]  tsize;

  always_comb begin
    iw = cfg.image_width;
    if (iw == '0) iw = nccm_pkg::SIZE_W'(1);
    else if (iw > nccm_pkg::SIZE_W'(nccm_pkg::MAX_IMAGE_WIDTH))
      iw = nccm_pkg::SIZE_W'(nccm_pkg::MAX_IMAGE_WIDTH);
    ih = cfg.image_height;
    if (ih == '0) ih = nccm_pkg::SIZE_W'(1);
    else if (ih > nccm_pkg::SIZE_W'(nccm_pkg::MAX_IMAGE_HEIGHT))
      ih = nccm_pkg::SIZE_W'(nccm_pkg::MAX_IMAGE_HEIGHT);
    tw = cfg.template_width;
    if (tw == '0) tw = nccm_pkg::TSIZE_W'(1);
    else if (tw > nccm_pkg::TSIZE_W'(TW)) tw = nccm_pkg::TSIZE_W'(TW);
    th = cfg.template_height;
    if (th == '0) th = nccm_pkg::TSIZE_W'(1);
    else if (th > nccm_pkg::TSIZE_W'(TH)) th = nccm_pkg::TSIZE_W'(TH);
    tsize = nccm_pkg::TPOS_W'(tw) * nccm_pkg::TPOS_W'(th);
  end

  // template load
  logic [PW-1:0]                  tmem [nccm_pkg::TDEPTH];
  logic [nccm_pkg::TPOS_W-1:0]    tpos_r, tpos_eff;
  logic [nccm_pkg::ACC_W-1:0]     te_r, te_eff;
  logic [nccm_pkg::TADDR_W-1:0]   taddr_r;
  logic [PW-1:0]                  tq_r;
  logic                           issuing_r;
  logic [2*PW-1:0]                tsq;

  assign tpos_eff = in_first ? '0 : tpos_r;
  assign te_eff   = in_first ? '0 : te_r;
  assign tsq      = in_pixel * in_pixel;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tpos_r <= '0;
      te_r   <= '0;
    end else if (cmd.tpl_load) begin
      if (tpos_eff < tsize) begin
        tpos_r <= tpos_eff + nccm_pkg::TPOS_W'(1);
        te_r   <= te_eff + nccm_pkg::ACC_W'(tsq);
      end else begin
        tpos_r <= tpos_eff;
        te_r   <= te_eff;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.tpl_load && tpos_eff < tsize) tmem[tpos_eff[nccm_pkg::TADDR_W-1:0]] <= in_pixel;
    if (issuing_r) tq_r <= tmem[taddr_r];
  end

  // image raster position and line store
  localparam int LINE_W_L = nccm_pkg::LINE_W;
  logic [LINE_W_L-1:0]          lmem [nccm_pkg::MAX_IMAGE_WIDTH];
  logic [LINE_W_L-1:0]          lm_q_r, lm_new;
  logic [nccm_pkg::ROW_W-1:0]   row_r;
  logic [nccm_pkg::COL_W-1:0]   col_r, col_eff;
  logic [PW-1:0]                px_r;
  logic [PW-1:0]                win_r [TH][TW];
  logic [nccm_pkg::POS_W-1:0]   res_row_r, res_col_r;

  assign col_eff = in_first ? '0 : col_r;

  always_comb begin
    lm_new = '0;
    for (int r = 0; r < TH - 2; r++) lm_new[r*PW +: PW] = lm_q_r[(r+1)*PW +: PW];
    lm_new[(TH-2)*PW +: PW] = px_r;
  end

  assign st.full = ((nccm_pkg::SIZE_W)'(row_r) + nccm_pkg::SIZE_W'(1) >=
                    nccm_pkg::SIZE_W'(th)) &&
                   ((nccm_pkg::SIZE_W)'(col_r) + nccm_pkg::SIZE_W'(1) >=
                    nccm_pkg::SIZE_W'(tw));

  always_ff @(posedge clk) begin
    if (cmd.img_take) lm_q_r <= lmem[col_eff];
    if (cmd.img_step) lmem[col_r] <= lm_new;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      col_r <= '0;
      for (int r = 0; r < TH; r++)
        for (int c = 0; c < TW; c++) win_r[r][c] <= '0;
    end else if (cmd.img_take) begin
      if (in_first) begin
        row_r <= '0;
        col_r <= '0;
      end
    end else if (cmd.img_step) begin
      for (int r = 0; r < TH; r++)
        for (int c = 0; c < TW - 1; c++) win_r[r][c] <= win_r[r][c+1];
      for (int r = 0; r < TH - 1; r++) win_r[r][TW-1] <= lm_q_r[r*PW +: PW];
      win_r[TH-1][TW-1] <= px_r;
      if ((nccm_pkg::SIZE_W)'(col_r) + nccm_pkg::SIZE_W'(1) >= iw) begin
        col_r <= '0;
        if ((nccm_pkg::SIZE_W)'(row_r) + nccm_pkg::SIZE_W'(1) >= ih) row_r <= '0;
        else row_r <= row_r + nccm_pkg::ROW_W'(1);
      end else begin
        col_r <= col_r + nccm_pkg::COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.img_take) px_r <= in_pixel;
    if (cmd.img_step) begin
      res_row_r <= nccm_pkg::POS_W'((nccm_pkg::SIZE_W)'(row_r) + nccm_pkg::SIZE_W'(1)
                                    - nccm_pkg::SIZE_W'(th));
      res_col_r <= nccm_pkg::POS_W'((nccm_pkg::SIZE_W)'(col_r) + nccm_pkg::SIZE_W'(1)
                                    - nccm_pkg::SIZE_W'(tw));
    end
  end

  // correlation accumulation pipeline
  logic [nccm_pkg::TR_W-1:0]   ar_r;
  logic [nccm_pkg::TC_W-1:0]   ac_r;
  logic [nccm_pkg::TSIZE_W-1:0] wrow, wcol;
  logic [PW-1:0]               wq_r;
  logic                        v1_r, v2_r;
  logic [2*PW-1:0]             pc_r, pw_r;
  logic [nccm_pkg::ACC_W-1:0]  cc_r, we_r;
  logic                        issue_last;

  assign wrow = nccm_pkg::TSIZE_W'(TH) - th + nccm_pkg::TSIZE_W'(ar_r);
  assign wcol = nccm_pkg::TSIZE_W'(TW) - tw + nccm_pkg::TSIZE_W'(ac_r);
  assign issue_last = (nccm_pkg::TSIZE_W'(ar_r) == th - nccm_pkg::TSIZE_W'(1)) &&
                      (nccm_pkg::TSIZE_W'(ac_r) == tw - nccm_pkg::TSIZE_W'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      issuing_r <= 1'b0;
      v1_r      <= 1'b0;
      v2_r      <= 1'b0;
    end else begin
      v1_r <= issuing_r;
      v2_r <= v1_r;
      if (cmd.acc_start) issuing_r <= 1'b1;
      else if (issuing_r && issue_last) issuing_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.acc_start) begin
      ar_r    <= '0;
      ac_r    <= '0;
      taddr_r <= '0;
      cc_r    <= '0;
      we_r    <= '0;
    end else begin
      if (issuing_r) begin
        wq_r    <= win_r[wrow[nccm_pkg::TR_W-1:0]][wcol[nccm_pkg::TC_W-1:0]];
        taddr_r <= taddr_r + nccm_pkg::TADDR_W'(1);
        if (nccm_pkg::TSIZE_W'(ac_r) == tw - nccm_pkg::TSIZE_W'(1)) begin
          ac_r <= '0;
          ar_r <= ar_r + nccm_pkg::TR_W'(1);
        end else begin
          ac_r <= ac_r + nccm_pkg::TC_W'(1);
        end
      end
      if (v1_r) begin
        pc_r <= wq_r * tq_r;
        pw_r <= wq_r * wq_r;
      end
      if (v2_r) begin
        cc_r <= cc_r + nccm_pkg::ACC_W'(pc_r);
        we_r <= we_r + nccm_pkg::ACC_W'(pw_r);
      end
    end
  end

  assign st.acc_done = !issuing_r && !v1_r && !v2_r;
  assign st.zero     = (te_r == '0) || (we_r == '0);

  // energy product, square root, division
  logic [nccm_pkg::HALF_W+nccm_pkg::ACC_W-1:0] plo_r, phi;
  logic [nccm_pkg::PROD_W-1:0] sval_r;
  logic [nccm_pkg::RREM_W-1:0] rrem_r, rrem_sh, rtrial;
  logic [nccm_pkg::ACC_W-1:0]  root_r;
  logic [nccm_pkg::NUM_W-1:0]  num_r, q_r;
  logic [nccm_pkg::DREM_W-1:0] drem_r, drem_sh;
  logic [nccm_pkg::IT_W-1:0]   it_r;
  logic [nccm_pkg::SCORE_W-1:0] score_sat;

  assign st.sqrt_last = it_r == nccm_pkg::IT_W'(nccm_pkg::SQRT_STEPS - 1);
  assign st.div_last  = it_r == nccm_pkg::IT_W'(nccm_pkg::DIV_STEPS - 1);

  assign phi     = te_r * we_r[nccm_pkg::ACC_W-1:nccm_pkg::HALF_W];
  assign rrem_sh = {rrem_r[nccm_pkg::RREM_W-3:0], sval_r[nccm_pkg::PROD_W-1 -: 2]};
  assign rtrial  = {2'b00, root_r, 2'b01};
  assign drem_sh = {drem_r[nccm_pkg::DREM_W-2:0], num_r[nccm_pkg::NUM_W-1]};

  always_ff @(posedge clk) begin
    if (cmd.mul0) plo_r <= te_r * we_r[nccm_pkg::HALF_W-1:0];
    if (cmd.mul1) begin
      sval_r <= nccm_pkg::PROD_W'(plo_r) +
                (nccm_pkg::PROD_W'(phi) << nccm_pkg::HALF_W);
      rrem_r <= '0;
      root_r <= '0;
      num_r  <= {cc_r, 16'd0};
      drem_r <= '0;
      q_r    <= '0;
      it_r   <= '0;
    end else if (cmd.sqrt_step) begin
      sval_r <= sval_r << 2;
      if (rrem_sh >= rtrial) begin
        rrem_r <= rrem_sh - rtrial;
        root_r <= {root_r[nccm_pkg::ACC_W-2:0], 1'b1};
      end else begin
        rrem_r <= rrem_sh;
        root_r <= {root_r[nccm_pkg::ACC_W-2:0], 1'b0};
      end
      it_r <= st.sqrt_last ? '0 : it_r + nccm_pkg::IT_W'(1);
    end else if (cmd.div_step) begin
      num_r <= num_r << 1;
      if (drem_sh >= nccm_pkg::DREM_W'(root_r)) begin
        drem_r <= drem_sh - nccm_pkg::DREM_W'(root_r);
        q_r    <= {q_r[nccm_pkg::NUM_W-2:0], 1'b1};
      end else begin
        drem_r <= drem_sh;
        q_r    <= {q_r[nccm_pkg::NUM_W-2:0], 1'b0};
      end
      it_r <= it_r + nccm_pkg::IT_W'(1);
    end
  end

  always_comb begin
    if (st.zero) score_sat = '0;
    else if (q_r > nccm_pkg::NUM_W'(nccm_pkg::SCORE_ONE)) score_sat = nccm_pkg::SCORE_ONE;
    else score_sat = q_r[nccm_pkg::SCORE_W-1:0];
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      res_row   <= res_row_r;
      res_col   <= res_col_r;
      res_score <= score_sat;
      res_zero  <= st.zero;
      res_above <= nccm_pkg::THR_W'(score_sat) > cfg.match_threshold;
    end
  end

endmodule

/* src/nccm_ctrl.sv */
// ----------------------------------------------------------------------------
// nccm_ctrl
// Controller: sequences pixel handling, accumulation, root and division,
// and owns the result valid flag.
// ----------------------------------------------------------------------------
module nccm_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_action,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  nccm_pkg::status_t  st,
  output nccm_pkg::cmd_t     cmd
);

  typedef enum logic [2:0] {
    S_IDLE, S_LSTEP, S_ACC, S_MUL0, S_MUL1, S_SQRT, S_DIV, S_FIN
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_ready  = state_r == S_IDLE;
  assign out_valid = out_valid_r;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_action) begin
            cmd.img_take = 1'b1;
            state_nxt    = S_LSTEP;
          end else begin
            cmd.tpl_load = 1'b1;
          end
        end
      end
      S_LSTEP: begin
        cmd.img_step = 1'b1;
        if (st.full) begin
          cmd.acc_start = 1'b1;
          state_nxt     = S_ACC;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_ACC: begin
        if (st.acc_done) state_nxt = st.zero ? S_FIN : S_MUL0;
      end
      S_MUL0: begin
        cmd.mul0  = 1'b1;
        state_nxt = S_MUL1;
      end
      S_MUL1: begin
        cmd.mul1  = 1'b1;
        state_nxt = S_SQRT;
      end
      S_SQRT: begin
        cmd.sqrt_step = 1'b1;
        if (st.sqrt_last) state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (st.div_last) state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    out_valid_nxt = cmd.out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
